/* hdl/acert_pkg.sv */
// shared constants for the modem command echo and response tracker
package acert_pkg;

  // default sizes
  localparam int unsigned CMD_MAX_DEF = 128;
  localparam int unsigned RX_MAX_DEF  = 256;

  // event kinds on the input beat
  localparam logic [1:0] EV_RX_BYTE  = 2'd0;
  localparam logic [1:0] EV_CMD_BYTE = 2'd1;
  localparam logic [1:0] EV_CMD_TOUT = 2'd2;
  localparam logic [1:0] EV_GAP_TOUT = 2'd3;

  // command status codes
  localparam logic [2:0] CS_IDLE = 3'd0;
  localparam logic [2:0] CS_ECHO = 3'd1;
  localparam logic [2:0] CS_EXEC = 3'd2;
  localparam logic [2:0] CS_RESP = 3'd3;
  localparam logic [2:0] CS_TOUT = 3'd4;
  localparam logic [2:0] CS_OK   = 3'd5;
  localparam logic [2:0] CS_ERR  = 3'd6;

  // data status codes
  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_RECV = 2'd1;
  localparam logic [1:0] DS_DONE = 2'd2;

  // store targets
  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_RESP = 2'd1;
  localparam logic [1:0] TGT_DATA = 2'd2;

  // timer requests
  localparam logic [2:0] TMR_NONE       = 3'd0;
  localparam logic [2:0] TMR_DATA_RESTART = 3'd1;
  localparam logic [2:0] TMR_CMD_START  = 3'd2;
  localparam logic [2:0] TMR_CMD_STOP   = 3'd3;
  localparam logic [2:0] TMR_DATA_STOP  = 3'd4;

  // link modes
  localparam logic LM_DATA = 1'b0;
  localparam logic LM_CMD  = 1'b1;

endpackage

/* hdl/at_command_echo_response_tracker.sv */
// modem link tracker: command store, echo check, response and data routing
// a beat is held in the input register, then its result in the result register
// throughput: one beat per cycle unless the output stalls, set by this register pair
// the command store is read ahead at the next echo position, with a bypass
// reset clears link mode, status codes, positions and handshake state at once
// the command store is not cleared; only entries written by the current command are read
module at_command_echo_response_tracker
  import acert_pkg::*;
#(
  parameter int unsigned CMD_MAX = CMD_MAX_DEF,
  parameter int unsigned RX_MAX  = RX_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] byte_in_i,
  input  logic       first_i,
  input  logic       last_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic       link_mode_o,
  output logic [2:0] command_status_o,
  output logic [1:0] data_status_o,
  output logic [1:0] store_target_o,
  output logic [7:0] store_index_o,
  output logic [7:0] store_byte_o,
  output logic       uart_valid_o,
  output logic [7:0] uart_byte_o,
  output logic [2:0] timer_action_o,
  output logic       send_crlf_o
);

  localparam int unsigned CmdAw  = (CMD_MAX > 1) ? $clog2(CMD_MAX) : 1;
  localparam logic [7:0]  CmdLim = 8'(CMD_MAX);
  localparam logic [7:0]  RxLast = 8'(RX_MAX - 1);

  // input register
  logic       in_vld_q;
  logic [1:0] ev_q;
  logic [7:0] byte_q;
  logic       first_q, last_q;

  // result register
  logic       out_vld_q;
  logic       acc_q, lm_q, uv_q, crlf_q;
  logic [2:0] cst_q, tmr_q;
  logic [1:0] dst_q, tgt_q;
  logic [7:0] sidx_q, sbyte_q, ubyte_q;

  // tracker state
  logic       mode_q, mode_d;
  logic [2:0] cs_q, cs_d;
  logic [1:0] ds_q, ds_d;
  logic [7:0] len_q, len_d;
  logic [7:0] epos_q, epos_d;
  logic       ediff_q, ediff_d;
  logic [7:0] rpos_q, rpos_d;
  logic [7:0] dpos_q, dpos_d;
  logic       load_q, load_d;
  logic       refuse_q, refuse_d;

  // command store access
  logic             we;
  logic [CmdAw-1:0] waddr, raddr;
  logic [7:0]       wdata, rdata, echo_ref;
  logic             byp_hit_q;
  logic [7:0]       byp_q;

  // result of the current beat
  logic       acc, uv, crlf, busy;
  logic [1:0] tgt;
  logic [2:0] tmr;
  logic [7:0] sidx, sbyte, ubyte;

  logic fire;

  // handshake
  assign fire       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      ev_q    <= mode_i;
      byte_q  <= byte_in_i;
      first_q <= first_i;
      last_q  <= last_i;
    end
  end

  // command store, read ahead at the next echo position
  acert_ram #(
    .Width(8),
    .Depth(CMD_MAX)
  ) u_cmd_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign raddr = epos_d[CmdAw-1:0];

  // bypass for a write to the address being read ahead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else begin
      byp_hit_q <= we && (waddr == raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_q <= wdata;
  end

  assign echo_ref = byp_hit_q ? byp_q : rdata;

  // event processing
  always_comb begin
    mode_d   = mode_q;
    cs_d     = cs_q;
    ds_d     = ds_q;
    len_d    = len_q;
    epos_d   = epos_q;
    ediff_d  = ediff_q;
    rpos_d   = rpos_q;
    dpos_d   = dpos_q;
    load_d   = load_q;
    refuse_d = refuse_q;
    acc      = 1'b0;
    uv       = 1'b0;
    crlf     = 1'b0;
    busy     = 1'b0;
    tgt      = TGT_NONE;
    tmr      = TMR_NONE;
    sidx     = 8'd0;
    sbyte    = 8'd0;
    ubyte    = 8'd0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = byte_q;

    if (fire) begin
      unique case (ev_q)
        EV_RX_BYTE: begin
          if (mode_q == LM_DATA) begin
            // data byte to the data buffer
            tmr = TMR_DATA_RESTART;
            if (ds_q != DS_RECV) begin
              dpos_d = 8'd0;
            end
            tgt    = TGT_DATA;
            sidx   = dpos_d;
            sbyte  = byte_q;
            dpos_d = (dpos_d < RxLast) ? dpos_d + 8'd1 : dpos_d;
            ds_d   = DS_RECV;
          end else if (cs_q == CS_ECHO) begin
            // echo compare against the stored command
            if (epos_q < len_q && echo_ref != byte_q) begin
              ediff_d = 1'b1;
            end
            if (epos_q != 8'hFF) begin
              epos_d = epos_q + 8'd1;
            end
            if (!load_d && epos_d >= len_d) begin
              if (ediff_d) begin
                cs_d   = CS_ERR;
                mode_d = LM_DATA;
              end else begin
                cs_d = CS_EXEC;
              end
            end
          end else if (cs_q == CS_EXEC || cs_q == CS_RESP) begin
            // response byte to the response buffer
            tmr    = TMR_DATA_RESTART;
            tgt    = TGT_RESP;
            sidx   = rpos_q;
            sbyte  = byte_q;
            rpos_d = (rpos_q < RxLast) ? rpos_q + 8'd1 : rpos_q;
            cs_d   = CS_RESP;
          end else if (cs_q == CS_TOUT) begin
            tmr = TMR_DATA_RESTART;
          end
        end
        EV_CMD_BYTE: begin
          if (first_q) begin
            // new command, busy check
            load_d   = 1'b0;
            refuse_d = 1'b0;
            if (mode_q == LM_CMD) begin
              busy = !(cs_q inside {CS_IDLE, CS_OK, CS_ERR});
            end else begin
              busy = (ds_q == DS_RECV);
            end
            if (busy) begin
              refuse_d = !last_q;
            end else begin
              acc     = 1'b1;
              we      = 1'b1;
              waddr   = '0;
              len_d   = 8'd1;
              epos_d  = 8'd0;
              ediff_d = 1'b0;
              rpos_d  = 8'd0;
              mode_d  = LM_CMD;
              cs_d    = CS_ECHO;
              tmr     = TMR_CMD_START;
              uv      = 1'b1;
              ubyte   = byte_q;
              load_d  = !last_q;
            end
          end else if (load_q) begin
            // command body, truncated at the store size
            acc = 1'b1;
            if (len_q < CmdLim) begin
              we    = 1'b1;
              waddr = len_q[CmdAw-1:0];
              len_d = len_q + 8'd1;
              uv    = 1'b1;
              ubyte = byte_q;
            end
            if (last_q) begin
              load_d = 1'b0;
              if (mode_q == LM_CMD && cs_q == CS_ECHO && epos_q >= len_d) begin
                if (ediff_q) begin
                  cs_d   = CS_ERR;
                  mode_d = LM_DATA;
                end else begin
                  cs_d = CS_EXEC;
                end
              end
            end
          end else if (refuse_q && last_q) begin
            refuse_d = 1'b0;
          end
        end
        EV_CMD_TOUT: begin
          if (mode_q == LM_CMD) begin
            cs_d = CS_TOUT;
            crlf = 1'b1;
          end
          tmr = TMR_CMD_STOP;
        end
        EV_GAP_TOUT: begin
          if (mode_q == LM_CMD) begin
            if (cs_q == CS_RESP) begin
              cs_d = CS_OK;
            end
            mode_d = LM_DATA;
          end else begin
            ds_d = DS_DONE;
          end
          tmr = TMR_DATA_STOP;
        end
        default: begin
          tmr = TMR_NONE;
        end
      endcase
    end
  end

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= LM_DATA;
      cs_q     <= CS_IDLE;
      ds_q     <= DS_IDLE;
      len_q    <= 8'd0;
      epos_q   <= 8'd0;
      ediff_q  <= 1'b0;
      rpos_q   <= 8'd0;
      dpos_q   <= 8'd0;
      load_q   <= 1'b0;
      refuse_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      cs_q     <= cs_d;
      ds_q     <= ds_d;
      len_q    <= len_d;
      epos_q   <= epos_d;
      ediff_q  <= ediff_d;
      rpos_q   <= rpos_d;
      dpos_q   <= dpos_d;
      load_q   <= load_d;
      refuse_q <= refuse_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q   <= acc;
      lm_q    <= mode_d;
      cst_q   <= cs_d;
      dst_q   <= ds_d;
      tgt_q   <= tgt;
      sidx_q  <= sidx;
      sbyte_q <= sbyte;
      uv_q    <= uv;
      ubyte_q <= ubyte;
      tmr_q   <= tmr;
      crlf_q  <= crlf;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign accepted_o       = acc_q;
  assign link_mode_o      = lm_q;
  assign command_status_o = cst_q;
  assign data_status_o    = dst_q;
  assign store_target_o   = tgt_q;
  assign store_index_o    = sidx_q;
  assign store_byte_o     = sbyte_q;
  assign uart_valid_o     = uv_q;
  assign uart_byte_o      = ubyte_q;
  assign timer_action_o   = tmr_q;
  assign send_crlf_o      = crlf_q;

  // a transmitted byte always belongs to an accepted command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && uart_valid_o |-> accepted_o)
    else $error("uart byte without accepted command");

  // response bytes only while the command is in its response phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_target_o == TGT_RESP |-> command_status_o == CS_RESP
      && link_mode_o == LM_CMD)
    else $error("response byte outside response phase");

  // data bytes only in data mode while receiving
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_target_o == TGT_DATA |-> link_mode_o == LM_DATA
      && data_status_o == DS_RECV)
    else $error("data byte outside data reception");

  // tracker state moves only when a beat is processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable({mode_q, cs_q, ds_q, len_q, epos_q, rpos_q, dpos_q, load_q}))
    else $error("tracker state changed without a beat");

endmodule

/* hdl/acert_ram.sv */
// generic single write port ram with registered read
module acert_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read, old data on a colliding read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
